[hw/rtl/set_assoc_lru_cache_hit_counter_core_defines.svh]
// Assertion macros shared by the cache hit counter RTL.
`ifndef SET_ASSOC_LRU_CACHE_HIT_COUNTER_CORE_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_HIT_COUNTER_CORE_DEFINES_SVH

// Checked on every clock edge outside reset.
`define SALC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define SALC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[hw/rtl/salc_pkg.sv]
// Types and constants of the set-associative LRU cache hit counter.
package salc_pkg;

  localparam int TagW    = 32;
  localparam int NumWays = 4;
  localparam int NumSets = 8;
  localparam int AgeW    = 8;

  localparam int WayW = (NumWays > 1) ? $clog2(NumWays) : 1;
  localparam int IdxW = (NumSets > 1) ? $clog2(NumSets) : 1;
  localparam logic [AgeW-1:0] AgeMax = '1;

  // Set index unit for set counts that are not a power of two.
  localparam int RemStep  = 4;
  localparam int RemSteps = TagW / RemStep;
  localparam int RemCntW  = $clog2(RemSteps);

  localparam int HitW       = 1;
  localparam int WayUsedW   = 2;
  localparam int CntW       = 32;
  localparam int OutFieldsW = HitW + WayUsedW + CntW + CntW;
  localparam int OutTdataW  = ((OutFieldsW + 7) / 8) * 8;
  localparam int OutPadW    = OutTdataW - OutFieldsW;

  typedef struct packed {
    logic [TagW-1:0] tag;
    logic [AgeW-1:0] age;
  } way_ent_t;

  typedef way_ent_t [NumWays-1:0] row_t;

  typedef struct packed {
    logic            hit;
    logic [WayW-1:0] way;
  } sel_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_IDX,
    S_LOOK
  } state_e;

endpackage

[hw/rtl/set_assoc_lru_cache_hit_counter_core.sv]
// Set-associative LRU cache model with hit and access counters.
//
// Input stream (s_axis): one 32-bit address per transaction.
// Output stream (m_axis): one result per address: hit flag, way used, and
// the running hit and access totals after that access.
// Each set is one row of a registered-read RAM (tags and ages of all ways);
// the valid bits of each set sit in flip-flops. An address goes through the
// set index step, a RAM read, and a compare/update step that writes the
// row back and loads the output register. Set counts that are not a power
// of two add a remainder iteration (4 address bits per cycle).
// A new address is accepted while an earlier result still waits on m_axis;
// if the receiver stalls, the update waits until the output register frees,
// and only one address is in flight at a time, so no forwarding is needed.
// Reset clears all valid bits, both counters and the output valid flag; the
// tag/age RAM needs no clearing since only valid ways are ever read.
`include "set_assoc_lru_cache_hit_counter_core_defines.svh"

module set_assoc_lru_cache_hit_counter_core import salc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // tdata: address[31:0]
  input  logic [TagW-1:0]      s_axis_tdata_i,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // tdata: hit[0], way_used[2:1], hit_total[34:3], access_total[66:35], zero pad
  output logic [OutTdataW-1:0] m_axis_tdata_o,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i
);

  state_e state_q, state_d;

  logic               in_accept;
  logic               idx_start;
  logic               ram_re;
  logic               look_done;

  logic [TagW-1:0]    addr_q;
  logic [IdxW-1:0]    set_q;
  logic               idx_valid;
  logic [IdxW-1:0]    idx;

  logic [NumWays-1:0] valid_q [NumSets];
  row_t               rd_row;
  row_t               wr_row;
  logic [NumWays-1:0] wr_valid;
  sel_t               sel;

  logic [CntW-1:0]    hit_cnt_q, hit_cnt_d;
  logic [CntW-1:0]    acc_cnt_q, acc_cnt_d;

  logic                out_valid_q;
  logic                out_hit_q;
  logic [WayUsedW-1:0] out_way_q;
  logic [CntW-1:0]     out_hit_tot_q;
  logic [CntW-1:0]     out_acc_tot_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d = S_IDX;
        end
      end
      S_IDX: begin
        if (idx_valid) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        if (!out_valid_q || m_axis_tready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    ram_re          = 1'b0;
    look_done       = 1'b0;
    case (state_q)
      S_IDLE:  s_axis_tready_o = 1'b1;
      S_IDX:   ram_re = idx_valid;
      S_LOOK:  look_done = !out_valid_q || m_axis_tready_i;
      default: s_axis_tready_o = 1'b0;
    endcase
  end

  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign idx_start = in_accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      addr_q <= s_axis_tdata_i;
    end
    if (ram_re) begin
      set_q <= idx;
    end
  end

  salc_set_idx u_set_idx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (idx_start),
    .addr_i      (addr_q),
    .idx_valid_o (idx_valid),
    .idx_o       (idx)
  );

  salc_row_ram #(
    .Width ($bits(row_t)),
    .Depth (NumSets),
    .AddrW (IdxW)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (look_done),
    .waddr_i (set_q),
    .wdata_i (wr_row),
    .re_i    (ram_re),
    .raddr_i (idx),
    .rdata_o (rd_row)
  );

  salc_way_sel u_way_sel (
    .row_i   (rd_row),
    .valid_i (valid_q[set_q]),
    .addr_i  (addr_q),
    .sel_o   (sel),
    .row_o   (wr_row),
    .valid_o (wr_valid)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NumSets; s++) begin
        valid_q[s] <= '0;
      end
    end else if (look_done) begin
      valid_q[set_q] <= wr_valid;
    end
  end

  assign hit_cnt_d = hit_cnt_q + CntW'(sel.hit);
  assign acc_cnt_d = acc_cnt_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_cnt_q   <= '0;
      acc_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (look_done) begin
        hit_cnt_q   <= hit_cnt_d;
        acc_cnt_q   <= acc_cnt_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (look_done) begin
      out_hit_q     <= sel.hit;
      out_way_q     <= WayUsedW'(sel.way);
      out_hit_tot_q <= hit_cnt_d;
      out_acc_tot_q <= acc_cnt_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{OutPadW{1'b0}}, out_acc_tot_q, out_hit_tot_q,
                            out_way_q, out_hit_q};

  // unwritten ways read as X, so compare with case equality
  `SALC_ASSERT(a_row_held_in_stall, (state_q == S_LOOK && !look_done) |=> (rd_row === $past(rd_row)), "set row changed while update stalled")
  `SALC_ASSERT(a_result_follows_update, look_done |=> m_axis_tvalid_o, "update did not present a result")
  `SALC_ASSERT(a_access_count_step, look_done |=> (acc_cnt_q == CntW'($past(acc_cnt_q) + 1'b1)), "access count did not advance by one")
  `SALC_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |-> !m_axis_tvalid_o, "result valid during reset")

endmodule

[hw/rtl/salc_row_ram.sv]
// Generic single-port-write, registered-read RAM holding one set per row.
module salc_row_ram #(
  parameter int Width = 8,
  parameter int Depth = 8,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/salc_set_idx.sv]
// Set index: address modulo the set count, a mask or a multi-cycle remainder.
module salc_set_idx import salc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [TagW-1:0] addr_i,
  output logic            idx_valid_o,
  output logic [IdxW-1:0] idx_o
);

  localparam bit IsPow2 = ((NumSets & (NumSets - 1)) == 0);

  logic            done_q;

  if (IsPow2) begin : g_mask
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else if (start_i) begin
        done_q <= 1'b1;
      end
    end

    // addr_i is held for the whole transaction, so the low bits serve directly
    assign idx_o = (NumSets == 1) ? '0 : addr_i[IdxW-1:0];
  end else begin : g_rem
    logic [IdxW-1:0]    rem_q;
    logic               busy_q;
    logic [RemCntW-1:0] cnt_q;
    logic [IdxW-1:0]    rem_d;
    logic [RemStep-1:0] nib;

    // restoring remainder, one nibble per cycle from the top
    always_comb begin
      logic [IdxW:0] t;
      nib = addr_i[(TagW - 1 - RemStep * int'(cnt_q)) -: RemStep];
      t   = {1'b0, rem_q};
      for (int k = RemStep - 1; k >= 0; k--) begin
        t = {t[IdxW-1:0], nib[k]};
        if (t >= (IdxW + 1)'(NumSets)) begin
          t = t - (IdxW + 1)'(NumSets);
        end
      end
      rem_d = t[IdxW-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        busy_q <= 1'b0;
        done_q <= 1'b0;
        cnt_q  <= '0;
      end else if (start_i) begin
        busy_q <= 1'b1;
        done_q <= 1'b0;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == RemCntW'(RemSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        rem_q <= '0;
      end else if (busy_q) begin
        rem_q <= rem_d;
      end
    end

    assign idx_o = rem_q;
  end

  assign idx_valid_o = done_q;

endmodule

[hw/rtl/salc_way_sel.sv]
// Tag compare, victim choice and age update for one set row.
module salc_way_sel import salc_pkg::*; (
  input  row_t                 row_i,
  input  logic [NumWays-1:0]   valid_i,
  input  logic [TagW-1:0]      addr_i,
  output sel_t                 sel_o,
  output row_t                 row_o,
  output logic [NumWays-1:0]   valid_o
);

  logic            hit;
  logic [WayW-1:0] hit_way;
  logic            have_empty;
  logic [WayW-1:0] empty_way;
  logic            have_old;
  logic [WayW-1:0] old_way;
  logic [AgeW-1:0] old_age;
  logic [WayW-1:0] chosen;

  always_comb begin
    hit        = 1'b0;
    hit_way    = '0;
    have_empty = 1'b0;
    empty_way  = '0;
    have_old   = 1'b0;
    old_way    = '0;
    old_age    = '0;
    for (int w = 0; w < NumWays; w++) begin
      if (valid_i[w]) begin
        if (!hit && row_i[w].tag == addr_i) begin
          hit     = 1'b1;
          hit_way = WayW'(w);
        end
        // >= lets a later way win a tie on age
        if (!have_old || row_i[w].age >= old_age) begin
          have_old = 1'b1;
          old_way  = WayW'(w);
          old_age  = row_i[w].age;
        end
      end else if (!have_empty) begin
        have_empty = 1'b1;
        empty_way  = WayW'(w);
      end
    end
    if (hit) begin
      chosen = hit_way;
    end else if (have_empty) begin
      chosen = empty_way;
    end else begin
      chosen = old_way;
    end
  end

  always_comb begin
    row_o   = row_i;
    valid_o = valid_i;
    for (int w = 0; w < NumWays; w++) begin
      if (WayW'(w) == chosen) begin
        row_o[w].tag = addr_i;
        row_o[w].age = '0;
        valid_o[w]   = 1'b1;
      end else if (valid_i[w] && row_i[w].age != AgeMax) begin
        row_o[w].age = row_i[w].age + 1'b1;
      end
    end
  end

  assign sel_o.hit = hit;
  assign sel_o.way = chosen;

endmodule
